// ===== rtl/fcpw_pkg.sv =====
// ----------------------------------------------------------------------------
// fcpw_pkg
// Shared codes, defaults and control/status bundles for the four-class
// priority worklist.
// ----------------------------------------------------------------------------
package fcpw_pkg;

    localparam int NODE_COUNT_DEF = 256;
    localparam int CLASS_COUNT    = 4;

    // request kinds (s_tuser)
    localparam logic [1:0] REQ_PUSH  = 2'd0;
    localparam logic [1:0] REQ_ERASE = 2'd1;
    localparam logic [1:0] REQ_POP   = 2'd2;
    localparam logic [1:0] REQ_QUERY = 2'd3;

    // list classes, in pop priority order
    localparam logic [1:0] CLS_EQ      = 2'd0;
    localparam logic [1:0] CLS_NN_POS  = 2'd1;
    localparam logic [1:0] CLS_NN_NEG  = 2'd2;
    localparam logic [1:0] CLS_REST    = 2'd3;

    // result status codes
    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_CONST     = 3'd1;
    localparam logic [2:0] STATUS_QUEUED    = 3'd2;
    localparam logic [2:0] STATUS_POP_EMPTY = 3'd3;
    localparam logic [2:0] STATUS_ABSENT    = 3'd4;

    typedef struct packed {
        logic clr;      // clear one queued flag
        logic accept;   // capture request, launch memory read
        logic exec;     // main update step
        logic fix;      // second link write of a push
        logic emit;     // load result into output register
    } fcpw_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic need_fix;
        logic out_free;
    } fcpw_stat_t;

endpackage

// ===== rtl/fcpw_ctrl.sv =====
// ----------------------------------------------------------------------------
// fcpw_ctrl
// Sequencer: flag clearing after reset, request capture, update and the
// optional second link write, plus the pending-result handoff.
// ----------------------------------------------------------------------------
module fcpw_ctrl
    import fcpw_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  fcpw_stat_t stat,
    output fcpw_cmd_t  cmd
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;
    localparam logic [1:0] ST_FIX   = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       pend_reg, pend_next;

    always_comb begin
        cmd.clr    = (state_reg == ST_CLEAR);
        cmd.emit   = (state_reg == ST_IDLE) && pend_reg && stat.out_free;
        s_tready   = (state_reg == ST_IDLE) && (!pend_reg || stat.out_free);
        cmd.accept = s_tready && s_tvalid;
        cmd.exec   = (state_reg == ST_EXEC);
        cmd.fix    = (state_reg == ST_FIX);
    end

    always_comb begin
        state_next = state_reg;
        pend_next  = pend_reg;
        if (cmd.emit) begin
            pend_next = 1'b0;
        end
        case (state_reg)
            ST_CLEAR: begin
                if (stat.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (cmd.accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (stat.need_fix) begin
                    state_next = ST_FIX;
                end else begin
                    state_next = ST_IDLE;
                    pend_next  = 1'b1;
                end
            end
            ST_FIX: begin
                state_next = ST_IDLE;
                pend_next  = 1'b1;
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    a_fix_after_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FIX |-> $past(state_reg) == ST_EXEC)
        else $error("fix step without preceding update step");

    a_emit_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> pend_reg)
        else $error("emit without a pending result");

    a_done_sets_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIX) |=> pend_reg && state_reg == ST_IDLE)
        else $error("result not pending after fix step");

endmodule

// ===== rtl/fcpw_dp.sv =====
// ----------------------------------------------------------------------------
// fcpw_dp
// Link memories, queued flags, list head/tail registers, result and
// output registers.
// ----------------------------------------------------------------------------
module fcpw_dp
    import fcpw_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [15:0] s_tdata,
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    input  fcpw_cmd_t   cmd,
    output fcpw_stat_t  stat
);

    localparam int IDX_W  = (NODE_COUNT > 2) ? $clog2(NODE_COUNT) : 1;
    localparam int LINK_W = $clog2(NODE_COUNT + 1);
    localparam logic [LINK_W-1:0] NONE = LINK_W'(NODE_COUNT);

    logic [LINK_W-1:0] next_mem [NODE_COUNT];
    logic [LINK_W-1:0] prev_mem [NODE_COUNT];
    logic              qflag_mem [NODE_COUNT];

    logic [LINK_W-1:0] hd_reg [CLASS_COUNT];
    logic [LINK_W-1:0] hd_next [CLASS_COUNT];
    logic [LINK_W-1:0] tl_reg [CLASS_COUNT];
    logic [LINK_W-1:0] tl_next [CLASS_COUNT];

    logic [IDX_W-1:0]  clr_cnt_reg;

    // captured request
    logic [1:0]        req_reg;
    logic [IDX_W-1:0]  node_reg;
    logic              inr_reg;
    logic              const_reg;
    logic [1:0]        cls_reg;
    logic              back_reg;

    // registered memory reads
    logic [LINK_W-1:0] nx_rd;
    logic [LINK_W-1:0] pv_rd;
    logic              qf_rd;

    // second link write
    logic              fix_next_sel_reg, fix_next_sel_next; // 1: next_mem, 0: prev_mem
    logic [IDX_W-1:0]  fix_addr_reg, fix_addr_next;
    logic              need_fix;

    // pending result
    logic [7:0]        res_node_reg, res_node_next;
    logic              res_pv_reg, res_pv_next;
    logic              res_mem_reg, res_mem_next;
    logic [2:0]        res_st_reg, res_st_next;

    logic [15:0]       m_tdata_reg;
    logic              m_tvalid_reg;

    // request decode
    logic [31:0]       id_ext;
    logic              id_inr;
    logic [IDX_W-1:0]  id_idx;
    logic              is_const, is_neg, is_norm, is_eq, is_leaf;
    logic [1:0]        in_cls;
    logic              hd_found;
    logic [IDX_W-1:0]  hd_idx;
    logic [IDX_W-1:0]  rd_addr;

    // memory write ports
    logic              nx_we, pv_we, qf_we;
    logic [IDX_W-1:0]  nx_wa, pv_wa, qf_wa;
    logic [LINK_W-1:0] nx_wd, pv_wd;
    logic              qf_wd;

    logic [LINK_W-1:0] n_link;
    logic              all_empty;

    assign id_ext   = 32'(s_tdata[7:0]);
    assign id_inr   = id_ext < 32'(NODE_COUNT);
    assign id_idx   = id_ext[IDX_W-1:0];
    assign is_const = s_tdata[8];
    assign is_neg   = s_tdata[9];
    assign is_norm  = s_tdata[10];
    assign is_eq    = s_tdata[11];
    assign is_leaf  = s_tdata[12];
    assign in_cls   = !is_norm ? (is_neg ? CLS_NN_NEG : CLS_NN_POS)
                               : (is_eq ? CLS_EQ : CLS_REST);

    // first non-empty list in priority order
    always_comb begin
        hd_found = 1'b0;
        hd_idx   = '0;
        for (int k = CLASS_COUNT - 1; k >= 0; k--) begin
            if (hd_reg[k] != NONE) begin
                hd_found = 1'b1;
                hd_idx   = hd_reg[k][IDX_W-1:0];
            end
        end
    end

    assign rd_addr = (s_tuser == REQ_POP) ? hd_idx : id_idx;
    assign n_link  = LINK_W'(node_reg);

    always_comb begin
        all_empty = 1'b1;
        for (int k = 0; k < CLASS_COUNT; k++) begin
            if (hd_reg[k] != NONE) begin
                all_empty = 1'b0;
            end
        end
    end

    // update step
    always_comb begin
        for (int k = 0; k < CLASS_COUNT; k++) begin
            hd_next[k] = hd_reg[k];
            tl_next[k] = tl_reg[k];
        end
        nx_we = 1'b0;  nx_wa = node_reg;  nx_wd = NONE;
        pv_we = 1'b0;  pv_wa = node_reg;  pv_wd = NONE;
        qf_we = 1'b0;  qf_wa = node_reg;  qf_wd = 1'b0;
        fix_next_sel_next = fix_next_sel_reg;
        fix_addr_next     = fix_addr_reg;
        need_fix          = 1'b0;
        res_node_next = res_node_reg;
        res_pv_next   = res_pv_reg;
        res_mem_next  = res_mem_reg;
        res_st_next   = res_st_reg;

        if (cmd.clr) begin
            qf_we = 1'b1;
            qf_wa = clr_cnt_reg;
            qf_wd = 1'b0;
        end else if (cmd.fix) begin
            if (fix_next_sel_reg) begin
                nx_we = 1'b1;
                nx_wa = fix_addr_reg;
                nx_wd = n_link;
            end else begin
                pv_we = 1'b1;
                pv_wa = fix_addr_reg;
                pv_wd = n_link;
            end
        end else if (cmd.exec) begin
            res_node_next = 8'd0;
            res_pv_next   = 1'b0;
            res_mem_next  = 1'b0;
            res_st_next   = STATUS_OK;
            case (req_reg)
                REQ_PUSH: begin
                    if (inr_reg && qf_rd) begin
                        res_st_next = STATUS_QUEUED;
                    end else if (!inr_reg || const_reg) begin
                        res_st_next = STATUS_CONST;
                    end else begin
                        qf_we = 1'b1;
                        qf_wd = 1'b1;
                        nx_we = 1'b1;
                        pv_we = 1'b1;
                        if (back_reg) begin
                            nx_wd = NONE;
                            pv_wd = tl_reg[cls_reg];
                            if (tl_reg[cls_reg] != NONE) begin
                                need_fix          = 1'b1;
                                fix_next_sel_next = 1'b1;
                                fix_addr_next     = tl_reg[cls_reg][IDX_W-1:0];
                            end else begin
                                hd_next[cls_reg] = n_link;
                            end
                            tl_next[cls_reg] = n_link;
                        end else begin
                            nx_wd = hd_reg[cls_reg];
                            pv_wd = NONE;
                            if (hd_reg[cls_reg] != NONE) begin
                                need_fix          = 1'b1;
                                fix_next_sel_next = 1'b0;
                                fix_addr_next     = hd_reg[cls_reg][IDX_W-1:0];
                            end else begin
                                tl_next[cls_reg] = n_link;
                            end
                            hd_next[cls_reg] = n_link;
                        end
                    end
                end
                REQ_ERASE, REQ_POP: begin
                    if (inr_reg && qf_rd) begin
                        qf_we = 1'b1;
                        qf_wd = 1'b0;
                        // predecessor side
                        if (pv_rd != NONE) begin
                            nx_we = 1'b1;
                            nx_wa = pv_rd[IDX_W-1:0];
                            nx_wd = nx_rd;
                        end else begin
                            for (int k = 0; k < CLASS_COUNT; k++) begin
                                if (hd_reg[k] == n_link) begin
                                    hd_next[k] = nx_rd;
                                end
                            end
                        end
                        // successor side
                        if (nx_rd != NONE) begin
                            pv_we = 1'b1;
                            pv_wa = nx_rd[IDX_W-1:0];
                            pv_wd = pv_rd;
                        end else begin
                            for (int k = 0; k < CLASS_COUNT; k++) begin
                                if (tl_reg[k] == n_link) begin
                                    tl_next[k] = pv_rd;
                                end
                            end
                        end
                        if (req_reg == REQ_POP) begin
                            res_node_next = 8'(32'(node_reg));
                            res_pv_next   = 1'b1;
                        end
                    end else begin
                        res_st_next = (req_reg == REQ_POP) ? STATUS_POP_EMPTY
                                                           : STATUS_ABSENT;
                    end
                end
                REQ_QUERY: begin
                    res_mem_next = inr_reg && qf_rd;
                end
                default: begin
                    res_st_next = STATUS_OK;
                end
            endcase
        end
    end

    // memories: one write and one registered read each
    always_ff @(posedge aclk) begin
        if (nx_we) begin
            next_mem[nx_wa] <= nx_wd;
        end
        if (cmd.accept) begin
            nx_rd <= next_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (pv_we) begin
            prev_mem[pv_wa] <= pv_wd;
        end
        if (cmd.accept) begin
            pv_rd <= prev_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (qf_we) begin
            qflag_mem[qf_wa] <= qf_wd;
        end
        if (cmd.accept) begin
            qf_rd <= qflag_mem[rd_addr];
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            req_reg   <= s_tuser;
            const_reg <= is_const;
            cls_reg   <= in_cls;
            back_reg  <= is_norm && !is_eq && is_leaf;
            if (s_tuser == REQ_POP) begin
                node_reg <= hd_idx;
                inr_reg  <= hd_found;
            end else begin
                node_reg <= id_idx;
                inr_reg  <= id_inr;
            end
        end
        fix_next_sel_reg <= fix_next_sel_next;
        fix_addr_reg     <= fix_addr_next;
        res_node_reg     <= res_node_next;
        res_pv_reg       <= res_pv_next;
        res_mem_reg      <= res_mem_next;
        res_st_reg       <= res_st_next;
        if (cmd.emit) begin
            m_tdata_reg <= {2'b00, res_st_reg, all_empty, res_mem_reg,
                            res_pv_reg, res_node_reg};
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < CLASS_COUNT; k++) begin
                hd_reg[k] <= NONE;
                tl_reg[k] <= NONE;
            end
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            for (int k = 0; k < CLASS_COUNT; k++) begin
                hd_reg[k] <= hd_next[k];
                tl_reg[k] <= tl_next[k];
            end
            if (cmd.clr) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign stat.need_fix   = need_fix;
    assign stat.clear_last = (clr_cnt_reg == IDX_W'(NODE_COUNT - 1));
    assign stat.out_free   = !m_tvalid_reg || m_tready;
    assign m_tvalid        = m_tvalid_reg;
    assign m_tdata         = m_tdata_reg;

    a_head_tail_agree: assert property (@(posedge aclk) disable iff (!aresetn)
        ((hd_reg[0] == NONE) == (tl_reg[0] == NONE)) &&
        ((hd_reg[1] == NONE) == (tl_reg[1] == NONE)) &&
        ((hd_reg[2] == NONE) == (tl_reg[2] == NONE)) &&
        ((hd_reg[3] == NONE) == (tl_reg[3] == NONE)))
        else $error("list head and tail disagree on emptiness");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_tvalid_reg || m_tready))
        else $error("result overwrote an untaken item");

    a_pop_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tdata_reg[8] |-> m_tdata_reg[13:11] == STATUS_OK)
        else $error("popped item carries an error status");

endmodule

// ===== rtl/four_class_priority_worklist.sv =====
// ----------------------------------------------------------------------------
// four_class_priority_worklist
// Four doubly linked node lists with push, erase, pop and membership query.
// ----------------------------------------------------------------------------
// One request in, one result out. After reset the block clears every queued
// flag and holds s_tready low meanwhile. A request then goes through capture
// with link read and update, plus a further link write step for a push
// that links to an existing list neighbor, since each link memory has a
// single write port. The result moves to the output register in the first
// idle cycle after the update in which that register is free, alongside any
// request accepted in that cycle; while one result waits there on m_tready
// and the next is already pending, s_tready stays low.
// ----------------------------------------------------------------------------
module four_class_priority_worklist
    import fcpw_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] node_id, [8] is_constant, [9] is_negated, [10] is_normal,
    // [11] is_equality, [12] is_leaf
    input  logic [15:0] s_tdata,
    // [1:0] req_type
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] popped_node, [8] popped_valid, [9] is_member, [10] all_empty,
    // [13:11] status
    output logic [15:0] m_tdata
);

    fcpw_cmd_t  cmd;
    fcpw_stat_t stat;

    fcpw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fcpw_dp #(
        .NODE_COUNT (NODE_COUNT)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

// ===== tb/sv/worklist_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// worklist_result_checker
// Watches both streams of the four-class priority worklist, keeps a shadow
// copy of the four linked lists, predicts the result of every accepted
// request and compares each returned item field by field, in order.
// ----------------------------------------------------------------------------
module worklist_result_checker
    import fcpw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    output int          mismatches,
    output int          pending
);

    localparam logic [8:0] NO_NODE = 9'd256;

    // packed so that the layout lines up with m_tdata[13:0]
    typedef struct packed {
        logic [2:0] status;
        logic       all_empty;
        logic       is_member;
        logic       popped_valid;
        logic [7:0] popped_node;
    } wl_result_t;

    logic [8:0] link_next [256];
    logic [8:0] link_prev [256];
    bit         on_list   [256];
    logic [8:0] head      [CLASS_COUNT];
    logic [8:0] tail      [CLASS_COUNT];

    wl_result_t request_outcomes [$];
    wl_result_t want, got;

    function automatic void clear_lists();
        for (int k = 0; k < CLASS_COUNT; k++) begin
            head[k] = NO_NODE;
            tail[k] = NO_NODE;
        end
        for (int n = 0; n < 256; n++) begin
            on_list[n] = 1'b0;
        end
    endfunction

    function automatic void link_front(logic [1:0] k, logic [7:0] n);
        logic [8:0] x;
        x = head[k];
        link_prev[n] = NO_NODE;
        link_next[n] = x;
        if (!x[8]) link_prev[x[7:0]] = {1'b0, n};
        else       tail[k] = {1'b0, n};
        head[k] = {1'b0, n};
        on_list[n] = 1'b1;
    endfunction

    function automatic void link_back(logic [1:0] k, logic [7:0] n);
        logic [8:0] p;
        p = tail[k];
        link_next[n] = NO_NODE;
        link_prev[n] = p;
        if (!p[8]) link_next[p[7:0]] = {1'b0, n};
        else       head[k] = {1'b0, n};
        tail[k] = {1'b0, n};
        on_list[n] = 1'b1;
    endfunction

    function automatic void unlink(logic [7:0] n);
        logic [8:0] p, x;
        p = link_prev[n];
        x = link_next[n];
        if (!p[8]) begin
            link_next[p[7:0]] = x;
        end else begin
            for (int k = 0; k < CLASS_COUNT; k++)
                if (head[k] == {1'b0, n}) head[k] = x;
        end
        if (!x[8]) begin
            link_prev[x[7:0]] = p;
        end else begin
            for (int k = 0; k < CLASS_COUNT; k++)
                if (tail[k] == {1'b0, n}) tail[k] = p;
        end
        on_list[n] = 1'b0;
    endfunction

    function automatic wl_result_t apply_request(logic [1:0] kind, logic [15:0] d);
        wl_result_t r;
        logic [7:0] id;
        logic [8:0] front;
        r = '0;
        r.status = STATUS_OK;
        id = d[7:0];
        case (kind)
            REQ_PUSH: begin
                // already-queued check wins over the constant check
                if (on_list[id])    r.status = STATUS_QUEUED;
                else if (d[8])      r.status = STATUS_CONST;
                else if (!d[10])    link_front(d[9] ? CLS_NN_NEG : CLS_NN_POS, id);
                else if (d[11])     link_front(CLS_EQ, id);
                else if (d[12])     link_back(CLS_REST, id);
                else                link_front(CLS_REST, id);
            end
            REQ_ERASE: begin
                if (on_list[id]) unlink(id);
                else             r.status = STATUS_ABSENT;
            end
            REQ_POP: begin
                front = NO_NODE;
                for (int k = 0; k < CLASS_COUNT; k++) begin
                    if (front[8] && !head[k][8]) front = head[k];
                end
                if (!front[8]) begin
                    unlink(front[7:0]);
                    r.popped_node  = front[7:0];
                    r.popped_valid = 1'b1;
                end else begin
                    r.status = STATUS_POP_EMPTY;
                end
            end
            REQ_QUERY: begin
                r.is_member = on_list[id];
            end
            default: ;
        endcase
        r.all_empty = 1'b1;
        for (int k = 0; k < CLASS_COUNT; k++)
            if (!head[k][8]) r.all_empty = 1'b0;
        return r;
    endfunction

    initial begin
        mismatches = 0;
        pending    = 0;
        clear_lists();
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_lists();
            request_outcomes.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = wl_result_t'(m_tdata[13:0]);
                if (request_outcomes.size() == 0) begin
                    $error("result item with no request outstanding: %h", m_tdata);
                    mismatches++;
                end else begin
                    want = request_outcomes.pop_front();
                    if (got.popped_node !== want.popped_node) begin
                        $error("popped_node: expected %0d, got %0d",
                               want.popped_node, got.popped_node);
                        mismatches++;
                    end
                    if (got.popped_valid !== want.popped_valid) begin
                        $error("popped_valid: expected %0d, got %0d",
                               want.popped_valid, got.popped_valid);
                        mismatches++;
                    end
                    if (got.is_member !== want.is_member) begin
                        $error("is_member: expected %0d, got %0d",
                               want.is_member, got.is_member);
                        mismatches++;
                    end
                    if (got.all_empty !== want.all_empty) begin
                        $error("all_empty: expected %0d, got %0d",
                               want.all_empty, got.all_empty);
                        mismatches++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d",
                               want.status, got.status);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                request_outcomes.push_back(apply_request(s_tuser, s_tdata));
        end
        pending = request_outcomes.size();
    end

endmodule

// ===== tb/sv/tb_four_class_priority_worklist.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_four_class_priority_worklist
// Drives push, erase, pop and query requests into the worklist: a directed
// pass over every placement rule and corner case, then biased random traffic
// under three idle/stall mixes. Result checking lives in the checker module.
// ----------------------------------------------------------------------------
module tb_four_class_priority_worklist;
    import fcpw_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int          RAND_ITEMS  = 510;

    // literal flags, packed as in s_tdata[12:8]
    localparam logic [4:0] F_NONE  = 5'b00000;
    localparam logic [4:0] F_CONST = 5'b00001;
    localparam logic [4:0] F_NEG   = 5'b00010;
    localparam logic [4:0] F_NORM  = 5'b00100;
    localparam logic [4:0] F_EQ    = 5'b01000;
    localparam logic [4:0] F_LEAF  = 5'b10000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = REQ_PUSH;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    int          mismatches;
    int          pending;
    int          snd_idle_pct = 30;
    int          rcv_idle_pct = 52;
    int unsigned cycle_count  = 0;

    four_class_priority_worklist uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    worklist_result_checker result_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .mismatches(mismatches),
        .pending   (pending)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_req(input logic [1:0] kind, input logic [7:0] id,
                            input logic [4:0] flags);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {3'b000, flags, id};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    initial begin
        logic [1:0] kind;
        logic [7:0] id;
        logic [4:0] flags;
        int         pick;

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: empty-list cases, every placement rule, unlink positions
        send_req(REQ_POP,   8'd0,   F_NONE);
        send_req(REQ_QUERY, 8'd0,   F_NONE);
        send_req(REQ_ERASE, 8'd5,   F_NONE);
        send_req(REQ_PUSH,  8'd0,   F_CONST | F_NORM);
        send_req(REQ_PUSH,  8'd255, F_NONE);
        send_req(REQ_PUSH,  8'd7,   F_NEG | F_EQ | F_LEAF);
        send_req(REQ_PUSH,  8'd9,   F_NORM | F_EQ);
        send_req(REQ_PUSH,  8'd3,   F_NORM | F_LEAF);
        send_req(REQ_PUSH,  8'd4,   F_NORM);
        send_req(REQ_PUSH,  8'd10,  F_NORM | F_LEAF | F_NEG);
        send_req(REQ_PUSH,  8'd11,  F_NORM | F_LEAF);
        send_req(REQ_PUSH,  8'd9,   F_CONST | F_NORM | F_EQ);  // already queued
        send_req(REQ_PUSH,  8'd12,  F_CONST | F_NEG);
        send_req(REQ_QUERY, 8'd255, F_NONE);
        send_req(REQ_ERASE, 8'd4,   F_NONE);                   // head of its list
        send_req(REQ_ERASE, 8'd10,  F_NONE);                   // middle
        send_req(REQ_ERASE, 8'd10,  F_NONE);                   // now absent
        send_req(REQ_QUERY, 8'd10,  F_NONE);
        send_req(REQ_POP,   8'd0,   F_NONE);
        send_req(REQ_POP,   8'd0,   F_NONE);
        send_req(REQ_POP,   8'd0,   F_NONE);
        send_req(REQ_ERASE, 8'd11,  F_NONE);                   // tail
        send_req(REQ_POP,   8'd0,   F_NONE);
        send_req(REQ_POP,   8'd0,   F_NONE);
        drain();

        // random traffic, ids mostly from a small pool so lists stay busy
        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (i == RAND_ITEMS / 3) begin
                snd_idle_pct = 52;
                rcv_idle_pct = 30;
            end else if (i == 2 * RAND_ITEMS / 3) begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            if (i % (RAND_ITEMS / 3) == RAND_ITEMS / 6) drain();

            pick = $urandom_range(99);
            if (pick < 42)      kind = REQ_PUSH;
            else if (pick < 60) kind = REQ_ERASE;
            else if (pick < 84) kind = REQ_POP;
            else                kind = REQ_QUERY;
            id = ($urandom_range(9) < 7) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
            flags = 5'($urandom_range(31));
            // constant literals are only occasional
            flags[0] = ($urandom_range(9) == 0);
            send_req(kind, id, flags);
        end

        drain();
        repeat (20) @(negedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
